// ===== design/predictive_adpcm_block_decoder_unit_macros.svh =====
// Assertion macros for the checker file.
`ifndef PREDICTIVE_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH
`define PREDICTIVE_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH

// Clocked check, muted while reset is held.
`define PADBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PADBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/padbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package padbd_pkg;

  localparam int NUM_LANES = 4;
  localparam int MERGE_DEPTH = 2 * NUM_LANES;

  localparam logic [4:0] HEADER_WORDS = 5'd4;
  localparam logic [4:0] LAST_WORD = 5'd18;

  localparam logic [3:0] ROW_BEATS = 4'd8;
  localparam logic [3:0] HDR_BEATS = 4'd2;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic       hdr_load;
    logic       step;
    logic [3:0] nibble;
  } lane_ctl_t;

  typedef struct packed {
    logic       load;
    logic       hdr;
    logic [1:0] grp;
    logic [3:0] row;
    logic       last;
  } merge_ld_t;

  // Q6 tap on the most recent sample
  function automatic logic signed [7:0] coef_recent(input logic [1:0] f);
    logic signed [7:0] c;
    case (f)
      2'd0: c = 8'sd0;
      2'd1: c = 8'sd60;
      2'd2: c = 8'sd115;
      2'd3: c = 8'sd98;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Q6 tap on the older sample
  function automatic logic signed [7:0] coef_older(input logic [1:0] f);
    logic signed [7:0] c;
    case (f)
      2'd0: c = 8'sd0;
      2'd1: c = 8'sd0;
      2'd2: c = -8'sd52;
      2'd3: c = -8'sd55;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/padbd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module padbd_lane (
  input  wire                  clk,
  input  wire                  rst_n,
  input  padbd_pkg::lane_ctl_t ctl,
  input  wire [31:0]           hdr_word,
  output padbd_pkg::sample_t   older,
  output padbd_pkg::sample_t   recent
);
  import padbd_pkg::*;

  sample_t          recent_r, recent_nxt;
  sample_t          older_r, older_nxt;
  logic [1:0]       filt_r, filt_nxt;
  logic [3:0]       shift_r, shift_nxt;

  logic signed [15:0] res;
  logic signed [7:0]  c1, c2;
  logic signed [25:0] res_x, p1, p2, acc, adj, quo;
  sample_t            dec;

  always_comb begin
    res   = $signed({ctl.nibble, 12'b0}) >>> shift_r;
    res_x = $signed({{4{res[15]}}, res, 6'b0});
    c1    = coef_recent(filt_r);
    c2    = coef_older(filt_r);
    p1    = $signed({{10{recent_r[15]}}, recent_r}) * $signed({{18{c1[7]}}, c1});
    p2    = $signed({{10{older_r[15]}}, older_r}) * $signed({{18{c2[7]}}, c2});
    acc   = res_x + p1 + p2;
    // truncate toward zero: bias negatives before the shift
    adj   = acc + (acc[25] ? 26'sd63 : 26'sd0);
    quo   = adj >>> 6;
    if (quo > 26'sd32767) begin
      dec = 16'sh7FFF;
    end else if (quo < -26'sd32768) begin
      dec = 16'sh8000;
    end else begin
      dec = quo[15:0];
    end
  end

  always_comb begin
    recent_nxt = recent_r;
    older_nxt  = older_r;
    filt_nxt   = filt_r;
    shift_nxt  = shift_r;
    if (ctl.hdr_load) begin
      filt_nxt   = hdr_word[1:0];
      shift_nxt  = hdr_word[19:16];
      older_nxt  = {hdr_word[15:4], 4'b0};
      recent_nxt = {hdr_word[31:20], 4'b0};
    end else if (ctl.step) begin
      older_nxt  = recent_r;
      recent_nxt = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      older_r  <= '0;
      filt_r   <= '0;
      shift_r  <= '0;
    end else begin
      recent_r <= recent_nxt;
      older_r  <= older_nxt;
      filt_r   <= filt_nxt;
      shift_r  <= shift_nxt;
    end
  end

  assign older  = older_r;
  assign recent = recent_r;

endmodule

`default_nettype wire

// ===== design/padbd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module padbd_merge (
  input  wire                                            clk,
  input  wire                                            rst_n,
  input  padbd_pkg::merge_ld_t                           ld,
  input  padbd_pkg::sample_t [padbd_pkg::NUM_LANES-1:0]  older,
  input  padbd_pkg::sample_t [padbd_pkg::NUM_LANES-1:0]  recent,
  output logic                                           can_load,
  output logic                                           out_valid,
  input  wire                                            out_stall,
  output logic signed [15:0]                             out_sample,
  output logic [6:0]                                     out_position,
  output logic                                           out_block_end
);
  import padbd_pkg::*;

  sample_t    samples_r [MERGE_DEPTH];
  sample_t    samples_nxt [MERGE_DEPTH];
  logic [3:0] count_r, count_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       hdr_r, hdr_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic [4:0] off_r, off_nxt;
  logic       last_r, last_nxt;
  logic       pop;
  logic [1:0] grp_sel;

  assign out_valid = (count_r != 4'd0);
  assign pop       = out_valid && !out_stall;
  assign can_load  = (count_r == 4'd0) || ((count_r == 4'd1) && pop);

  always_comb begin
    samples_nxt = samples_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hdr_nxt     = hdr_r;
    grp_nxt     = grp_r;
    off_nxt     = off_r;
    last_nxt    = last_r;
    if (pop) begin
      // advance the queue by one beat
      for (int i = 0; i < MERGE_DEPTH - 1; i++) begin
        samples_nxt[i] = samples_r[i + 1];
      end
      count_nxt = count_r - 4'd1;
      idx_nxt   = idx_r + 3'd1;
    end
    if (ld.load) begin
      idx_nxt  = '0;
      hdr_nxt  = ld.hdr;
      grp_nxt  = ld.grp;
      last_nxt = ld.last;
      if (ld.hdr) begin
        samples_nxt[0] = older[ld.grp];
        samples_nxt[1] = recent[ld.grp];
        count_nxt      = HDR_BEATS;
        off_nxt        = '0;
      end else begin
        for (int g = 0; g < NUM_LANES; g++) begin
          samples_nxt[2 * g]     = older[g];
          samples_nxt[2 * g + 1] = recent[g];
        end
        count_nxt = ROW_BEATS;
        off_nxt   = {ld.row, 1'b0} + 5'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      hdr_r   <= 1'b0;
      grp_r   <= '0;
      off_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      hdr_r   <= hdr_nxt;
      grp_r   <= grp_nxt;
      off_r   <= off_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samples_r <= samples_nxt;
  end

  assign grp_sel       = hdr_r ? grp_r : idx_r[2:1];
  assign out_sample    = samples_r[0];
  assign out_position  = {grp_sel, off_r + {4'b0, idx_r[0]}};
  assign out_block_end = last_r && (idx_r == 3'd7);

endmodule

`default_nettype wire

// ===== design/predictive_adpcm_block_decoder_unit.sv =====
// Path: a header word's seeds are written into one lane's registers and then
//   wait in HOLD for the result queue; a row word's samples pass the lane
//   registers in IDLE (high nibbles) and STEP (low nibbles), then wait in HOLD.
// Output: a row word gives 8 result beats on the single output port, a header
//   word two seed beats; input stalls outside IDLE, but the next word can be taken while the queue still drains.
// Reset (rst_n low, synchronous): word position, all lane histories, filters,
//   shifts and the result queue clear; the block then expects a group-0 header.
`timescale 1ns / 1ps
`default_nettype none

module predictive_adpcm_block_decoder_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire [31:0]         in_word,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_sample,
  output logic [6:0]         out_position,
  output logic               out_block_end
);
  import padbd_pkg::*;

  // Sequencer: IDLE takes a beat, STEP runs the second nibble of a row in
  // every lane, HOLD waits until the result queue can take the lane outputs.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic       hdr_r, hdr_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic [3:0] row_r, row_nxt;
  logic       last_r, last_nxt;
  logic [4:0] row_full;

  lane_ctl_t  lane_ctl [NUM_LANES];
  sample_t [NUM_LANES-1:0] lane_older;
  sample_t [NUM_LANES-1:0] lane_recent;
  merge_ld_t  mld;
  logic       can_load;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign row_full = pos_r - HEADER_WORDS;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    hdr_nxt   = hdr_r;
    grp_nxt   = grp_r;
    row_nxt   = row_r;
    last_nxt  = last_r;
    mld       = '0;
    for (int g = 0; g < NUM_LANES; g++) begin
      lane_ctl[g] = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt  = (pos_r >= LAST_WORD) ? 5'd0 : pos_r + 5'd1;
          word_nxt = in_word;
          grp_nxt  = pos_r[1:0];
          row_nxt  = row_full[3:0];
          last_nxt = (pos_r == LAST_WORD);
          if (pos_r < HEADER_WORDS) begin
            // header: reload one lane, seeds go straight out
            hdr_nxt                     = 1'b1;
            lane_ctl[pos_r[1:0]].hdr_load = 1'b1;
            state_nxt                   = ST_HOLD;
          end else begin
            // row: every lane decodes its high nibble now
            hdr_nxt = 1'b0;
            for (int g = 0; g < NUM_LANES; g++) begin
              lane_ctl[g].step   = 1'b1;
              lane_ctl[g].nibble = in_word[8 * g + 4 +: 4];
            end
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        for (int g = 0; g < NUM_LANES; g++) begin
          lane_ctl[g].step   = 1'b1;
          lane_ctl[g].nibble = word_r[8 * g +: 4];
        end
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        // lane history now holds both results of each group
        if (can_load) begin
          mld.load  = 1'b1;
          mld.hdr   = hdr_r;
          mld.grp   = grp_r;
          mld.row   = row_r;
          mld.last  = last_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      hdr_r   <= 1'b0;
      grp_r   <= '0;
      row_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      grp_r   <= grp_nxt;
      row_r   <= row_nxt;
      last_r  <= last_nxt;
    end
  end

  // hold the row word for the second nibble
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    padbd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl[g]),
      .hdr_word (word_nxt),
      .older    (lane_older[g]),
      .recent   (lane_recent[g])
    );
  end

  padbd_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (mld),
    .older         (lane_older),
    .recent        (lane_recent),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_position  (out_position),
    .out_block_end (out_block_end)
  );

endmodule

`default_nettype wire

// ===== design/padbd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "predictive_adpcm_block_decoder_unit_macros.svh"

module padbd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_sample,
  input wire [6:0]  out_position,
  input wire        out_block_end
);

  logic [23:0] beat;

  assign beat = {out_sample, out_position, out_block_end};

  // a stalled result beat holds
  `PADBD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(beat), "stalled beat changed")

  // one word at a time: stall right after every accepted beat
  `PADBD_ASSERT(a_in_one_at_a_time, in_valid && !in_stall |=> in_stall, "input beat taken back to back")

  // block end marks the final sample position only
  `PADBD_ASSERT(a_end_pos, out_valid && out_block_end |-> out_position == 7'd127, "block end on wrong position")

  // no result beats straight out of reset
  `PADBD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind predictive_adpcm_block_decoder_unit padbd_checker u_padbd_checker (.*);

`default_nettype wire
